// ----- rtl/kese_pkg.sv -----
// ----------------------------------------------------------------------------
// kese_pkg
// Shared types, key codes and byte constants for the key to escape sequence
// encoder.
// ----------------------------------------------------------------------------
package kese_pkg;

   localparam int unsigned MaxLen   = 7;
   localparam int unsigned LenWidth = 3;

   // Control and special bytes.
   localparam logic [7:0] ByteNul   = 8'h00;
   localparam logic [7:0] ByteBs    = 8'h08;
   localparam logic [7:0] ByteEsc   = 8'h1B;
   localparam logic [7:0] ByteDel   = 8'h7F;
   localparam logic [7:0] ByteLbr   = 8'h5B;  // '['
   localparam logic [7:0] ByteSs3   = 8'h4F;  // 'O'
   localparam logic [7:0] ByteOne   = 8'h31;  // '1'
   localparam logic [7:0] ByteSemi  = 8'h3B;  // ';'
   localparam logic [7:0] ByteTilde = 8'h7E;  // '~'
   localparam logic [7:0] ByteZ     = 8'h5A;  // 'Z'
   localparam logic [7:0] ByteZero  = 8'h30;  // '0'
   localparam logic [7:0] ByteP     = 8'h50;  // 'P'

   // Virtual-key codes with special handling.
   localparam logic [7:0] KeyBack  = 8'h08;
   localparam logic [7:0] KeyTab   = 8'h09;
   localparam logic [7:0] KeySpace = 8'h20;
   localparam logic [7:0] KeyF1    = 8'h70;
   localparam logic [7:0] KeyF4    = 8'h73;

   typedef logic [MaxLen-1:0][7:0] seq_bytes_type;

   typedef struct packed {
      logic [7:0] key_code;
      logic       shift_held;
      logic       alt_held;
      logic       ctrl_held;
   } key_type;

   // Encoded sequence handed from the encoder to the serializer.
   typedef struct packed {
      logic                valid;
      logic [LenWidth-1:0] len;
      seq_bytes_type       bytes;
   } seq_type;

   // Final byte of a cursor key, zero when the code is not a cursor key.
   function automatic logic [7:0] cursor_final(input logic [7:0] code);
      logic [7:0] fin;
      unique case (code)
         8'h26:   fin = 8'h41;  // Up -> 'A'
         8'h28:   fin = 8'h42;  // Down -> 'B'
         8'h27:   fin = 8'h43;  // Right -> 'C'
         8'h25:   fin = 8'h44;  // Left -> 'D'
         8'h24:   fin = 8'h48;  // Home -> 'H'
         8'h23:   fin = 8'h46;  // End -> 'F'
         default: fin = 8'h00;
      endcase
      return fin;
   endfunction

   // Number of a CSI n~ key, zero when the code is not one.
   function automatic logic [4:0] numbered_value(input logic [7:0] code);
      logic [4:0] num;
      unique case (code)
         8'h2D:   num = 5'd2;
         8'h2E:   num = 5'd3;
         8'h21:   num = 5'd5;
         8'h22:   num = 5'd6;
         8'h74:   num = 5'd15;
         8'h75:   num = 5'd17;
         8'h76:   num = 5'd18;
         8'h77:   num = 5'd19;
         8'h78:   num = 5'd20;
         8'h79:   num = 5'd21;
         8'h7A:   num = 5'd23;
         8'h7B:   num = 5'd24;
         default: num = 5'd0;
      endcase
      return num;
   endfunction

endpackage

// ----- rtl/kese_encoder.sv -----
// ----------------------------------------------------------------------------
// kese_encoder
// Input register and the combinational encoder that turns one registered key
// press into a byte sequence of up to seven bytes.
// ----------------------------------------------------------------------------
module kese_encoder
   import kese_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       app_cursor,
   input  logic       take,
   input  logic       key_valid,
   output logic       key_ready,
   input  key_type    key,
   output seq_type    seq
);

   logic    in_valid_ff;
   logic    in_valid_in;
   key_type in_key_ff;

   logic [7:0]          fin;
   logic [4:0]          num;
   logic [3:0]          mod_val;
   logic                modified;
   logic [7:0]          mod_char;
   logic [3:0]          tens;
   logic [4:0]          ones;
   logic [LenWidth-1:0] n;
   seq_bytes_type       b;

   assign key_ready   = !in_valid_ff || take;
   assign in_valid_in = (key_valid && key_ready) || (in_valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (key_valid && key_ready) begin
         in_key_ff <= key;
      end
   end

   always_comb begin
      mod_val  = 4'd1 + {3'd0, in_key_ff.shift_held} + {2'd0, in_key_ff.alt_held, 1'b0}
               + {1'b0, in_key_ff.ctrl_held, 2'b0};
      modified = in_key_ff.shift_held || in_key_ff.alt_held || in_key_ff.ctrl_held;
      mod_char = ByteZero + {4'd0, mod_val};

      fin = cursor_final(in_key_ff.key_code);
      if (fin == 8'h00 && in_key_ff.key_code >= KeyF1 && in_key_ff.key_code <= KeyF4) begin
         fin = ByteP + {6'd0, in_key_ff.key_code[1:0]};
      end

      num = numbered_value(in_key_ff.key_code);
      if (num >= 5'd20) begin
         tens = 4'd2;
         ones = num - 5'd20;
      end else if (num >= 5'd10) begin
         tens = 4'd1;
         ones = num - 5'd10;
      end else begin
         tens = 4'd0;
         ones = num;
      end

      b = '0;
      n = '0;
      priority if (fin != 8'h00) begin
         b[0] = ByteEsc;
         if (modified) begin
            b[1] = ByteLbr;
            b[2] = ByteOne;
            b[3] = ByteSemi;
            b[4] = mod_char;
            b[5] = fin;
            n    = LenWidth'(6);
         end else begin
            // Function keys always use SS3; cursor keys only in application mode.
            b[1] = (in_key_ff.key_code >= KeyF1 || app_cursor) ? ByteSs3 : ByteLbr;
            b[2] = fin;
            n    = LenWidth'(3);
         end
      end else if (num != 5'd0) begin
         b[0] = ByteEsc;
         b[1] = ByteLbr;
         n    = LenWidth'(2);
         if (tens != 4'd0) begin
            b[n] = ByteZero + {4'd0, tens};
            n    = n + LenWidth'(1);
         end
         b[n] = ByteZero + {3'd0, ones};
         n    = n + LenWidth'(1);
         if (modified) begin
            b[n] = ByteSemi;
            n    = n + LenWidth'(1);
            b[n] = mod_char;
            n    = n + LenWidth'(1);
         end
         b[n] = ByteTilde;
         n    = n + LenWidth'(1);
      end else if (in_key_ff.key_code == KeySpace && in_key_ff.ctrl_held
                   && !in_key_ff.alt_held) begin
         b[0] = ByteNul;
         n    = LenWidth'(1);
      end else if (in_key_ff.key_code == KeyBack) begin
         if (in_key_ff.alt_held) begin
            b[0] = ByteEsc;
            n    = LenWidth'(1);
         end
         b[n] = in_key_ff.ctrl_held ? ByteBs : ByteDel;
         n    = n + LenWidth'(1);
      end else if (in_key_ff.key_code == KeyTab && in_key_ff.shift_held
                   && !in_key_ff.ctrl_held && !in_key_ff.alt_held) begin
         b[0] = ByteEsc;
         b[1] = ByteLbr;
         b[2] = ByteZ;
         n    = LenWidth'(3);
      end else begin
         n = '0;
      end

      seq.valid = in_valid_ff;
      seq.len   = n;
      seq.bytes = b;
   end

endmodule

// ----- rtl/kese_serializer.sv -----
// ----------------------------------------------------------------------------
// kese_serializer
// Result register that holds one encoded sequence and hands it out one byte
// per transaction, loading the next sequence when empty or as the last byte leaves.
// ----------------------------------------------------------------------------
module kese_serializer
   import kese_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  seq_type    seq,
   output logic       take,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       out_last
);

   logic [LenWidth-1:0] count_ff;
   logic [LenWidth-1:0] count_in;
   seq_bytes_type       bytes_ff;
   seq_bytes_type       bytes_in;
   logic                load;

   // Free when empty or when the last byte leaves in this cycle.
   assign take = (count_ff == '0) || (count_ff == LenWidth'(1) && out_ready);
   assign load = take && seq.valid;

   assign out_valid = count_ff != '0;
   assign out_byte  = bytes_ff[0];
   assign out_last  = count_ff == LenWidth'(1);

   always_comb begin
      count_in = count_ff;
      bytes_in = bytes_ff;
      priority if (load) begin
         count_in = seq.len;
         bytes_in = seq.bytes;
      end else if (out_valid && out_ready) begin
         count_in = count_ff - LenWidth'(1);
         bytes_in = bytes_ff >> 8;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LenWidth'(MaxLen))
      else $error("byte count exceeds the longest sequence");

   a_mid_keeps_valid: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_ready && !out_last |=> out_valid)
      else $error("sequence ended before its last byte");

   a_last_then_reload: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_ready && out_last && !seq.valid |=> !out_valid)
      else $error("bytes emitted with no sequence loaded");
`endif

endmodule

// ----- rtl/key_to_escape_sequence_encoder_core.sv -----
// ----------------------------------------------------------------------------
// key_to_escape_sequence_encoder_core
// Encodes one key press into its xterm escape sequence, one byte per result
// transaction.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  key_code, shift/alt/ctrl held
//  rsp      out        rsp_valid / rsp_ready  out_byte, last_byte
//  csr      in         csr_valid / csr_ready  app_cursor (cursor key mode)
//
// A key press is registered, encoded combinationally and loaded into the output
// register, which sends one byte per cycle while rsp_ready is high: a press
// yields 1 to 7 bytes, and a key with no sequence sends none.
// The output register is the limit; the next press is taken while the current
// sequence drains. Reset clears the valid flags and the cursor key mode.
// A stalled rsp_ready holds the current byte and backs up req_ready.
// ----------------------------------------------------------------------------
module key_to_escape_sequence_encoder_core
   import kese_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_key_code,
   input  logic       req_shift_held,
   input  logic       req_alt_held,
   input  logic       req_ctrl_held,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_byte,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_app_cursor
);

   logic    app_cursor_ff;
   logic    app_cursor_in;
   logic    take;
   key_type key;
   seq_type seq;

   assign csr_ready     = 1'b1;
   assign app_cursor_in = (csr_valid && csr_ready) ? csr_app_cursor : app_cursor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         app_cursor_ff <= 1'b0;
      end else begin
         app_cursor_ff <= app_cursor_in;
      end
   end

   assign key.key_code   = req_key_code;
   assign key.shift_held = req_shift_held;
   assign key.alt_held   = req_alt_held;
   assign key.ctrl_held  = req_ctrl_held;

   kese_encoder u_encoder (
      .clock      (clock),
      .reset      (reset),
      .app_cursor (app_cursor_ff),
      .take       (take),
      .key_valid  (req_valid),
      .key_ready  (req_ready),
      .key        (key),
      .seq        (seq)
   );

   kese_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .seq       (seq),
      .take      (take),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_byte  (rsp_out_byte),
      .out_last  (rsp_last_byte)
   );

endmodule

// ----- test/key_to_escape_sequence_encoder_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_to_escape_sequence_encoder_core_tb
// Drives key presses into the encoder and compares every emitted byte with a
// prediction made inside the bench. A short table of presses covers the edge
// cases first, and random presses follow across several cursor-mode settings.
// Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module key_to_escape_sequence_encoder_core_tb;
   import kese_pkg::*;

   localparam int QuietLimit = 3000;

   // Key codes that the bench names on top of those in the package.
   localparam logic [7:0] KeyPgUp  = 8'h21;
   localparam logic [7:0] KeyPgDn  = 8'h22;
   localparam logic [7:0] KeyEnd   = 8'h23;
   localparam logic [7:0] KeyHome  = 8'h24;
   localparam logic [7:0] KeyLeft  = 8'h25;
   localparam logic [7:0] KeyUp    = 8'h26;
   localparam logic [7:0] KeyRight = 8'h27;
   localparam logic [7:0] KeyDown  = 8'h28;
   localparam logic [7:0] KeyIns   = 8'h2D;
   localparam logic [7:0] KeyDel   = 8'h2E;
   localparam logic [7:0] KeyF2    = 8'h71;
   localparam logic [7:0] KeyF3    = 8'h72;
   localparam logic [7:0] KeyF5    = 8'h74;
   localparam logic [7:0] KeyF6    = 8'h75;
   localparam logic [7:0] KeyF7    = 8'h76;
   localparam logic [7:0] KeyF8    = 8'h77;
   localparam logic [7:0] KeyF9    = 8'h78;
   localparam logic [7:0] KeyF10   = 8'h79;
   localparam logic [7:0] KeyF11   = 8'h7A;
   localparam logic [7:0] KeyF12   = 8'h7B;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } seq_byte_type;

   typedef struct packed {
      logic [7:0]      key;
      logic            shift;
      logic            alt;
      logic            ctrl;
      logic            mode;
      logic            typed;
      logic [3:0]      typed_len;
      logic [6:0][7:0] typed_bytes;
   } press_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_key_code;
   logic       req_shift_held;
   logic       req_alt_held;
   logic       req_ctrl_held;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_byte;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_app_cursor;

   seq_byte_type  pending_bytes[$];
   press_row_type directed_presses[$];
   logic          cursor_mode;
   logic          steady_tail;
   int            mismatch_count;
   int            quiet_cycles;
   int            stall_left;
   seq_byte_type  head;

   key_to_escape_sequence_encoder_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key_code   (req_key_code),
      .req_shift_held (req_shift_held),
      .req_alt_held   (req_alt_held),
      .req_ctrl_held  (req_ctrl_held),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_byte  (rsp_last_byte),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_app_cursor (csr_app_cursor)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Appends the bytes that one key press should produce.
   function automatic void encode_key_press(input logic [7:0] key, input logic sh,
                                            input logic al, input logic ct,
                                            input logic app);
      logic [7:0]   seq[$];
      logic [3:0]   mod;
      logic [7:0]   fin;
      int           num;
      seq_byte_type entry;
      mod = 4'(1 + sh + 2 * al + 4 * ct);
      unique case (key)
         KeyUp:    fin = "A";
         KeyDown:  fin = "B";
         KeyRight: fin = "C";
         KeyLeft:  fin = "D";
         KeyHome:  fin = "H";
         KeyEnd:   fin = "F";
         default:  fin = 8'h00;
      endcase
      if (key >= KeyF1 && key <= KeyF4)
         fin = ByteP + (key - KeyF1);
      unique case (key)
         KeyIns:  num = 2;
         KeyDel:  num = 3;
         KeyPgUp: num = 5;
         KeyPgDn: num = 6;
         KeyF5:   num = 15;
         KeyF6:   num = 17;
         KeyF7:   num = 18;
         KeyF8:   num = 19;
         KeyF9:   num = 20;
         KeyF10:  num = 21;
         KeyF11:  num = 23;
         KeyF12:  num = 24;
         default: num = 0;
      endcase
      if (fin != 8'h00) begin
         seq.insert(seq.size(), ByteEsc);
         if (mod != 4'd1) begin
            seq.insert(seq.size(), ByteLbr);
            seq.insert(seq.size(), ByteOne);
            seq.insert(seq.size(), ByteSemi);
            seq.insert(seq.size(), ByteZero + {4'd0, mod});
         end else if (key >= KeyF1 || app) begin
            seq.insert(seq.size(), ByteSs3);
         end else begin
            seq.insert(seq.size(), ByteLbr);
         end
         seq.insert(seq.size(), fin);
      end else if (num != 0) begin
         seq.insert(seq.size(), ByteEsc);
         seq.insert(seq.size(), ByteLbr);
         if (num >= 10)
            seq.insert(seq.size(), ByteZero + 8'(num / 10));
         seq.insert(seq.size(), ByteZero + 8'(num % 10));
         if (mod != 4'd1) begin
            seq.insert(seq.size(), ByteSemi);
            seq.insert(seq.size(), ByteZero + {4'd0, mod});
         end
         seq.insert(seq.size(), ByteTilde);
      end else if (key == KeySpace && ct && !al) begin
         seq.insert(seq.size(), ByteNul);
      end else if (key == KeyBack) begin
         if (al)
            seq.insert(seq.size(), ByteEsc);
         seq.insert(seq.size(), ct ? ByteBs : ByteDel);
      end else if (key == KeyTab && sh && !ct && !al) begin
         seq.insert(seq.size(), ByteEsc);
         seq.insert(seq.size(), ByteLbr);
         seq.insert(seq.size(), ByteZ);
      end
      for (int k = 0; k < seq.size(); k++) begin
         entry.value = seq[k];
         entry.last  = (k == seq.size() - 1);
         pending_bytes.insert(pending_bytes.size(), entry);
      end
   endfunction

   function automatic void add_press(input logic [7:0] key, input int sh, input int al,
                                     input int ct, input int mode, input int typed,
                                     input int len, input logic [6:0][7:0] bytes);
      press_row_type row;
      row.key         = key;
      row.shift       = 1'(sh);
      row.alt         = 1'(al);
      row.ctrl        = 1'(ct);
      row.mode        = 1'(mode);
      row.typed       = 1'(typed);
      row.typed_len   = 4'(len);
      row.typed_bytes = bytes;
      directed_presses.insert(directed_presses.size(), row);
   endfunction

   function automatic void note_mismatch(input string what, input logic [7:0] exp_val,
                                         input logic [7:0] act_val);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %02h, got %02h", what, exp_val, act_val);
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_key(input logic [7:0] key, input logic sh, input logic al,
                           input logic ct);
      if (!steady_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_key_code   <= key;
      req_shift_held <= sh;
      req_alt_held   <= al;
      req_ctrl_held  <= ct;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // A press with no bytes may still be inside the block when the queue empties,
   // so a few extra cycles pass before returning.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_cursor_mode(input logic mode);
      csr_valid      <= 1'b1;
      csr_app_cursor <= mode;
      do @(posedge clock); while (!csr_ready);
      cursor_mode = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result side: random stall bursts until the steady tail of the run.
   initial begin
      rsp_ready  = 1'b1;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!steady_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_bytes.size() == 0) begin
            note_mismatch("unexpected byte", 8'h00, rsp_out_byte);
         end else begin
            head = pending_bytes.pop_front();
            if (rsp_out_byte !== head.value)
               note_mismatch("out_byte", head.value, rsp_out_byte);
            if (rsp_last_byte !== head.last)
               note_mismatch("last_byte", {7'd0, head.last}, {7'd0, rsp_last_byte});
         end
      end
   end

   // Ends the run when no transaction of any kind has been seen for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      press_row_type row;
      seq_byte_type  row_byte;
      logic [7:0]    key;
      int            pick;
      logic          mode;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_key_code   = 8'h00;
      req_shift_held = 1'b0;
      req_alt_held   = 1'b0;
      req_ctrl_held  = 1'b0;
      csr_valid      = 1'b0;
      csr_app_cursor = 1'b0;
      cursor_mode    = 1'b0;
      steady_tail    = 1'b0;
      mismatch_count = 0;
      quiet_cycles   = 0;

      add_press(KeyUp,    0, 0, 0, 0, 1, 3, 56'({ByteEsc, ByteLbr, 8'h41}));
      add_press(8'h00,    1, 1, 1, 0, 1, 0, '0);
      add_press(8'hFF,    1, 1, 1, 0, 1, 0, '0);
      add_press(KeySpace, 0, 0, 1, 0, 1, 1, 56'({ByteNul}));
      add_press(KeySpace, 0, 1, 1, 0, 1, 0, '0);
      add_press(KeySpace, 1, 0, 1, 0, 1, 1, 56'({ByteNul}));
      add_press(KeyBack,  0, 0, 0, 0, 1, 1, 56'({ByteDel}));
      add_press(KeyBack,  1, 0, 0, 0, 1, 1, 56'({ByteDel}));
      add_press(KeyBack,  0, 1, 1, 0, 1, 2, 56'({ByteEsc, ByteBs}));
      add_press(KeyBack,  0, 1, 0, 0, 0, 0, '0);
      add_press(KeyTab,   1, 0, 0, 0, 1, 3, 56'({ByteEsc, ByteLbr, ByteZ}));
      add_press(KeyTab,   1, 0, 1, 0, 1, 0, '0);
      add_press(KeyTab,   0, 0, 0, 0, 1, 0, '0);
      add_press(KeyF1,    0, 0, 0, 0, 1, 3, 56'({ByteEsc, ByteSs3, ByteP}));
      add_press(KeyF4,    1, 1, 1, 0, 1, 6,
                56'({ByteEsc, ByteLbr, ByteOne, ByteSemi, 8'h38, 8'h53}));
      add_press(KeyF12,   1, 1, 1, 0, 1, 7,
                {ByteEsc, ByteLbr, 8'h32, 8'h34, ByteSemi, 8'h38, ByteTilde});
      add_press(KeyIns,   0, 0, 0, 0, 1, 4, 56'({ByteEsc, ByteLbr, 8'h32, ByteTilde}));
      add_press(KeyPgUp,  0, 0, 1, 0, 0, 0, '0);
      add_press(KeyHome,  0, 1, 0, 0, 0, 0, '0);
      add_press(KeyF5,    1, 0, 0, 0, 0, 0, '0);
      add_press(KeyDel,   0, 0, 0, 0, 0, 0, '0);
      add_press(KeyUp,    0, 0, 0, 1, 1, 3, 56'({ByteEsc, ByteSs3, 8'h41}));
      add_press(KeyLeft,  1, 0, 0, 1, 0, 0, '0);
      add_press(KeyEnd,   0, 0, 0, 1, 0, 0, '0);
      add_press(KeyF2,    0, 0, 0, 1, 0, 0, '0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_cursor_mode(1'b0);

      foreach (directed_presses[r]) begin
         row = directed_presses[r];
         if (row.mode != cursor_mode) begin
            wait_for_drain();
            write_cursor_mode(row.mode);
         end
         send_key(row.key, row.shift, row.alt, row.ctrl);
         if (row.typed) begin
            for (int k = 0; k < int'(row.typed_len); k++) begin
               row_byte.value = row.typed_bytes[3'(int'(row.typed_len) - 1 - k)];
               row_byte.last  = (k == int'(row.typed_len) - 1);
               pending_bytes.insert(pending_bytes.size(), row_byte);
            end
         end else begin
            encode_key_press(row.key, row.shift, row.alt, row.ctrl, cursor_mode);
         end
      end

      // Random presses, mostly keys that have a sequence, over five mode phases.
      for (int phase = 0; phase < 5; phase++) begin
         wait_for_drain();
         mode = (phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : 1'($urandom_range(0, 1));
         write_cursor_mode(mode);
         for (int i = 0; i < 57; i++) begin
            if (phase == 2 && i == 31)
               wait_for_drain();
            if (phase == 4 && i == 20)
               steady_tail = 1'b1;
            pick = $urandom_range(0, 33);
            unique case (pick)
               0:  key = KeyUp;
               1:  key = KeyDown;
               2:  key = KeyRight;
               3:  key = KeyLeft;
               4:  key = KeyHome;
               5:  key = KeyEnd;
               6:  key = KeyF1;
               7:  key = KeyF2;
               8:  key = KeyF3;
               9:  key = KeyF4;
               10: key = KeyIns;
               11: key = KeyDel;
               12: key = KeyPgUp;
               13: key = KeyPgDn;
               14: key = KeyF5;
               15: key = KeyF6;
               16: key = KeyF7;
               17: key = KeyF8;
               18: key = KeyF9;
               19: key = KeyF10;
               20: key = KeyF11;
               21: key = KeyF12;
               22: key = KeyBack;
               23: key = KeyTab;
               24: key = KeySpace;
               default: key = 8'($urandom_range(0, 255));
            endcase
            begin
               logic sh, al, ct;
               sh = 1'($urandom_range(0, 1));
               al = 1'($urandom_range(0, 1));
               ct = 1'($urandom_range(0, 1));
               send_key(key, sh, al, ct);
               encode_key_press(key, sh, al, ct, cursor_mode);
            end
         end
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (pending_bytes.size() != 0) begin
         mismatch_count += pending_bytes.size();
         $display("%0d expected bytes never arrived", pending_bytes.size());
      end
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
